### hdl/sha512_pkg.sv
// ----------------------------------------------------------------------------
// SHA-512 package
// Round constants, initial hash values and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sha512_pkg;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 80;
  localparam logic [7:0]  PadMark    = 8'h80;
  localparam logic [6:0]  LenOffset  = 7'd112;

  // Queue entry between the byte front end and the block engine.
  typedef struct packed {
    logic [1023:0] block;
    logic          last;   // final block of a message
  } blk_t;

  function automatic logic [63:0] round_k(input logic [6:0] i);
    logic [63:0] k;
    unique case (i)
      7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] init_h(input logic [2:0] i);
    logic [63:0] h;
    unique case (i)
      3'd0: h = 64'h6a09e667f3bcc908;
      3'd1: h = 64'hbb67ae8584caa73b;
      3'd2: h = 64'h3c6ef372fe94f82b;
      3'd3: h = 64'ha54ff53a5f1d36f1;
      3'd4: h = 64'h510e527fade682d1;
      3'd5: h = 64'h9b05688c2b3e6c1f;
      3'd6: h = 64'h1f83d9abfb41bd6b;
      default: h = 64'h5be0cd19137e2179;
    endcase
    return h;
  endfunction

endpackage
`default_nettype wire

### hdl/sha512_if.sv
// ----------------------------------------------------------------------------
// SHA-512 stream interfaces
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface sha512_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       final_req;
  modport source (output valid, data_byte, has_byte, final_req, input ready);
  modport sink   (input valid, data_byte, has_byte, final_req, output ready);
endinterface

interface sha512_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

### hdl/sha512_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-512 stream hasher
// Byte-stream SHA-512 with padding and eight-word digest output.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the front end is filling and the block
//   queue has room; the one-round-per-cycle engine takes no new block until
//   it is through with the last. Output: once the closing block or blocks and
//   any blocks already queued have passed the engine, the digest follows at
//   one word per accepted output cycle.
// Reset: async active low; chaining state returns to the initial values.
`timescale 1ns / 1ps
`default_nettype none
module sha512_stream_hasher (
  input  wire          clk_i,
  input  wire          rst_ni,
  sha512_in_if.sink    in_if,
  sha512_out_if.source out_if
);
  import sha512_pkg::*;

  // front end -> queue -> engine
  logic blk_valid, blk_ready, q_valid, q_ready;
  blk_t blk, q_blk;

  sha512_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .data_byte_i(in_if.data_byte),
    .has_byte_i (in_if.has_byte),
    .final_req_i(in_if.final_req),
    .blk_valid_o(blk_valid),
    .blk_ready_i(blk_ready),
    .blk_o      (blk)
  );

  sha512_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(blk_valid), .wr_ready_o(blk_ready), .wr_data_i(blk),
    .rd_valid_o(q_valid),   .rd_ready_i(q_ready),   .rd_data_o(q_blk)
  );

  sha512_engine u_engine (
    .clk_i, .rst_ni,
    .blk_valid_i  (q_valid),
    .blk_ready_o  (q_ready),
    .blk_i        (q_blk),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .digest_word_o(out_if.digest_word),
    .word_index_o (out_if.word_index),
    .last_word_o  (out_if.last_word)
  );

`ifndef NO_ASSERTIONS
  // Digest words come out in order.
  a_idx_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.ready && !out_if.last_word |=>
      out_if.word_index == $past(out_if.word_index) + 3'd1)
    else $error("digest word order");
  // The front end never offers a block into a full queue without holding it.
  a_blk_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_valid && !blk_ready |=> blk_valid)
    else $error("block dropped");
  // Last flag only on word seven.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.last_word == (out_if.word_index == 3'd7)))
    else $error("last flag");
`endif

endmodule
`default_nettype wire

### hdl/sha512_front.sv
// ----------------------------------------------------------------------------
// SHA-512 front end
// Packs bytes into blocks, counts length and builds padding blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sha512_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire  [7:0]            data_byte_i,
  input  wire                   has_byte_i,
  input  wire                   final_req_i,
  output logic                  blk_valid_o,
  input  wire                   blk_ready_i,
  output sha512_pkg::blk_t      blk_o
);
  import sha512_pkg::*;

  localparam logic [1:0] StFill = 2'd0;
  localparam logic [1:0] StPad  = 2'd1;  // extra block then length block
  localparam logic [1:0] StLen  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [1023:0] buf_q, buf_d;
  logic [6:0]    fill_q, fill_d;
  logic [127:0]  len_q, len_d;
  logic          ov_q, ov_d;    // output block register
  blk_t          ob_q, ob_d;
  // Set when the mark went out in an extra block.
  logic          pad_done_q, pad_done_d;

  logic          out_free;
  logic [1023:0] mark_buf, pad_buf, len_buf;
  logic [7:0]    pos;

  assign out_free    = !ov_q || blk_ready_i;
  assign in_ready_o  = (state_q == StFill) && out_free;
  assign blk_valid_o = ov_q;
  assign blk_o       = ob_q;

  // Byte p lives at bits [1023-8p -: 8]; the byte at fill gets the mark, bytes above fill are zeroed.
  always_comb begin
    mark_buf = buf_q;
    pos = 8'(fill_q);
    for (int b = 0; b < 128; b++) begin
      if (8'(b) == pos) mark_buf[1023-8*b -: 8] = PadMark;
      else if (8'(b) > pos) mark_buf[1023-8*b -: 8] = 8'h00;
    end
    pad_buf = mark_buf;
    len_buf = {mark_buf[1023:128], len_q};
  end

  always_comb begin
    state_d = state_q;
    buf_d   = buf_q;
    fill_d  = fill_q;
    len_d   = len_q;
    ov_d    = ov_q && !blk_ready_i;
    ob_d    = ob_q;
    unique case (state_q)
      StFill: begin
        if (in_valid_i && in_ready_o) begin
          if (has_byte_i) begin
            buf_d[1023-8*fill_q -: 8] = data_byte_i;
            len_d  = len_q + 128'd8;
            fill_d = fill_q + 7'd1;
            if (fill_q == 7'd127) begin
              ob_d = '{block: buf_d, last: 1'b0};
              ov_d = 1'b1;
              fill_d = '0;
              if (final_req_i) state_d = StLen;
            end else if (final_req_i) begin
              state_d = (fill_d >= LenOffset) ? StPad : StLen;
            end
          end else if (final_req_i) begin
            state_d = (fill_q >= LenOffset) ? StPad : StLen;
          end
        end
      end
      StPad: begin
        if (out_free) begin
          ob_d = '{block: pad_buf, last: 1'b0};
          ov_d = 1'b1;
          // mark already placed; the length block is all zero up to the length
          buf_d  = '0;
          fill_d = 7'd0;
          state_d = StLen;
        end
      end
      default: begin
        if (out_free) begin
          // after an extra block, the buffer is zero and no mark is wanted
          ob_d = '{block: (fill_q == 7'd0 && buf_q == '0 && pad_done_q) ?
                         {896'b0, len_q} : len_buf, last: 1'b1};
          ov_d = 1'b1;
          buf_d = '0;
          fill_d = '0;
          len_d = '0;
          state_d = StFill;
        end
      end
    endcase
  end

  always_comb begin
    pad_done_d = pad_done_q;
    if (state_q == StPad && out_free) pad_done_d = 1'b1;
    else if (state_q == StLen && out_free) pad_done_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StFill;
      fill_q     <= '0;
      len_q      <= '0;
      ov_q       <= 1'b0;
      pad_done_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      len_q      <= len_d;
      ov_q       <= ov_d;
      pad_done_q <= pad_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    ob_q  <= ob_d;
  end

endmodule
`default_nettype wire

### hdl/sha512_fifo.sv
// ----------------------------------------------------------------------------
// SHA-512 block queue
// Two-entry queue of blocks between front end and engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sha512_fifo (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               wr_valid_i,
  output logic              wr_ready_o,
  input  sha512_pkg::blk_t  wr_data_i,
  output logic              rd_valid_o,
  input  wire               rd_ready_i,
  output sha512_pkg::blk_t  rd_data_o
);
  import sha512_pkg::*;

  blk_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule
`default_nettype wire

### hdl/sha512_engine.sv
// ----------------------------------------------------------------------------
// SHA-512 compression engine
// One round per cycle, rolling message schedule, digest output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sha512_engine (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               blk_valid_i,
  output logic              blk_ready_o,
  input  sha512_pkg::blk_t  blk_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [63:0]       digest_word_o,
  output logic [2:0]        word_index_o,
  output logic              last_word_o
);
  import sha512_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StAdd  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]  state_q;
  logic [6:0]  rnd_q;
  logic        last_q;
  logic [63:0] h_q [8];
  logic [63:0] v_q [8];
  logic [63:0] w_q [16];
  logic [2:0]  oi_q;

  logic [63:0] t1, t2, s0, s1, wn, a, e;

  function automatic logic [63:0] ror(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  assign a  = v_q[0];
  assign e  = v_q[4];
  assign t1 = v_q[7] + (ror(e, 14) ^ ror(e, 18) ^ ror(e, 41))
            + ((e & v_q[5]) ^ (~e & v_q[6])) + round_k(rnd_q) + w_q[0];
  assign t2 = (ror(a, 28) ^ ror(a, 34) ^ ror(a, 39))
            + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  assign s0 = ror(w_q[1], 1) ^ ror(w_q[1], 8) ^ (w_q[1] >> 7);
  assign s1 = ror(w_q[14], 19) ^ ror(w_q[14], 61) ^ (w_q[14] >> 6);
  assign wn = s1 + w_q[9] + s0 + w_q[0];

  assign blk_ready_o   = state_q == StIdle;
  assign out_valid_o   = state_q == StOut;
  assign digest_word_o = h_q[oi_q];
  assign word_index_o  = oi_q;
  assign last_word_o   = oi_q == 3'd7;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rnd_q   <= '0;
      oi_q    <= '0;
      last_q  <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
    end else begin
      unique case (state_q)
        StIdle: if (blk_valid_i) begin
          state_q <= StRun;
          rnd_q   <= '0;
          last_q  <= blk_i.last;
        end
        StRun: if (rnd_q == 7'(Rounds - 1)) state_q <= StAdd;
               else rnd_q <= rnd_q + 7'd1;
        StAdd: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          state_q <= last_q ? StOut : StIdle;
          oi_q    <= '0;
        end
        default: if (out_ready_i) begin
          oi_q <= oi_q + 3'd1;
          if (oi_q == 3'd7) begin
            state_q <= StIdle;
            for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && blk_valid_i) begin
      for (int i = 0; i < 16; i++) w_q[i] <= blk_i.block[1023-64*i -: 64];
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (state_q == StRun) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

endmodule
`default_nettype wire
